[rtl/relocation_writeback_batcher_defines.svh]
// ----------------------------------------------------------------------------
// Relocation writeback batcher assertion macros
// Shared property shorthands for the batcher's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef RELOCATION_WRITEBACK_BATCHER_DEFINES_SVH
`define RELOCATION_WRITEBACK_BATCHER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled in reset.
`define RWB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on clk and disabled in reset.
`define RWB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rwb_pkg.sv]
// ----------------------------------------------------------------------------
// Relocation writeback batcher package
// Word types, codes and sizing constants shared by the batcher modules.
// ----------------------------------------------------------------------------
package rwb_pkg;

  localparam int MAX_BATCH = 16;
  localparam int CNT_W     = $clog2(MAX_BATCH + 1);
  localparam int IDX_W     = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int CAP_W     = 5;
  localparam int TMO_W     = 32;
  localparam int CLK_W     = 64;
  localparam int ID_W      = 32;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam logic [1:0] MODE_RECORD  = 2'd0;
  localparam logic [1:0] MODE_COMMIT  = 2'd1;
  localparam logic [1:0] MODE_ADVANCE = 2'd2;
  localparam logic [1:0] MODE_SYNC    = 2'd3;

  localparam logic KIND_RELOC  = 1'b0;
  localparam logic KIND_COMMIT = 1'b1;

  localparam logic REG_CAPACITY = 1'b0;
  localparam logic REG_TIMEOUT  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_AGE,
    ST_FLUSH,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [7:0]  file_number;
    logic [31:0] chunk_number;
    logic [31:0] segment_number;
    logic [63:0] from_location;
    logic [63:0] to_location;
    logic [31:0] op_increment;
  } in_word_t;

  typedef struct packed {
    logic        record_kind;
    logic [31:0] transaction_number;
    logic [7:0]  out_file;
    logic [31:0] out_chunk;
    logic [31:0] out_segment;
    logic [63:0] out_from;
    logic [63:0] out_to;
    logic        last_of_batch;
  } out_word_t;

  typedef struct packed {
    logic [7:0]      file;
    logic [31:0]     chunk;
    logic [31:0]     segment;
    logic [63:0]     from_loc;
    logic [63:0]     to_loc;
    logic [ID_W-1:0] id;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } st_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
  } st_rd_t;

endpackage

[rtl/rwb_store.sv]
// ----------------------------------------------------------------------------
// Relocation writeback batcher record store
// Pending-batch memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rwb_store (
  input  logic            clk,
  input  rwb_pkg::st_wr_t wr,
  input  rwb_pkg::st_rd_t rd,
  output rwb_pkg::entry_t rd_data
);
  import rwb_pkg::*;

  entry_t mem [MAX_BATCH];
  entry_t rd_q_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_q_r <= mem[rd.addr];
    end
  end

  assign rd_data = rd_q_r;

endmodule

[rtl/relocation_writeback_batcher.sv]
// ----------------------------------------------------------------------------
// Relocation writeback batcher
// Stamps relocation records with transaction ids, holds them in a pending
// batch and writes the batch back on capacity, timeout or sync.
// ----------------------------------------------------------------------------
// A relocation word that does not fill the batch is taken while the block is
// idle and written straight into the record store. A commit word holds the
// block until its record can load, since the record waits until the output
// register and any batch records ahead of it have moved on. An advance word
// first adds to the operation clock, then compares the batch age with the
// timeout. A flush of n records drains the store through its single read
// port, one record per cycle while the sink accepts, and no new word is taken
// until the last record is read. The store needs no clearing after reset.
module relocation_writeback_batcher (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rwb_pkg::in_word_t                  in_word,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rwb_pkg::out_word_t                 out_word,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [rwb_pkg::PADDR_W-1:0]        paddr,
  input  logic [rwb_pkg::PDATA_W-1:0]        pwdata,
  output logic [rwb_pkg::PDATA_W-1:0]        prdata,
  output logic                               pready
);
  import rwb_pkg::*;

  `include "relocation_writeback_batcher_defines.svh"

  state_t           state_r, state_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [TMO_W-1:0] tmo_r;
  logic [CNT_W-1:0] pending_r;
  logic [CNT_W-1:0] flush_n_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [CLK_W-1:0] op_clock_r;
  logic [CLK_W-1:0] start_r;
  logic [ID_W-1:0]  next_id_r;
  logic             rd_v_r;
  logic             rd_last_r;
  logic [7:0]       cmt_file_r;
  logic [31:0]      cmt_chunk_r;
  logic [ID_W-1:0]  cmt_id_r;
  logic             out_valid_r;
  out_word_t        out_word_r;

  logic [CNT_W-1:0] cap_eff;
  logic [CNT_W-1:0] pend_inc;
  logic             batch_full;
  logic             in_acc;
  logic             store_rec;
  logic             timed_out;
  logic             out_free;
  logic             mv_rd;
  logic             ld_cmt;
  logic             issue;
  logic             issue_last;
  logic             flush_go;
  st_wr_t           st_wr;
  st_rd_t           st_rd;
  entry_t           st_q;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIMEOUT) ? tmo_r : PDATA_W'(cap_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_W'(16);
      tmo_r <= TMO_W'(1024);
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_CAPACITY) begin
        cap_r <= pwdata[CAP_W-1:0];
      end else begin
        tmo_r <= pwdata;
      end
    end
  end

  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_r) > 32'(MAX_BATCH)) begin
      cap_eff = CNT_W'(MAX_BATCH);
    end else begin
      cap_eff = CNT_W'(cap_r);
    end
  end

  assign pend_inc   = pending_r + CNT_W'(1);
  assign batch_full = (pending_r == CNT_W'(MAX_BATCH));
  assign in_acc     = in_valid && in_ready;
  assign store_rec  = in_acc && (in_word.mode == MODE_RECORD) && !batch_full;
  assign timed_out  = (pending_r != '0) && ((op_clock_r - start_r) >= CLK_W'(tmo_r));
  assign issue_last = (CNT_W'(rd_idx_r) + CNT_W'(1)) == flush_n_r;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_word.mode)
            MODE_RECORD: begin
              if (batch_full || pend_inc >= cap_eff) begin
                state_nxt = ST_FLUSH;
              end
            end
            MODE_COMMIT:  state_nxt = ST_COMMIT;
            MODE_ADVANCE: state_nxt = ST_AGE;
            MODE_SYNC: begin
              if (pending_r != '0) begin
                state_nxt = ST_FLUSH;
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_AGE: begin
        state_nxt = timed_out ? ST_FLUSH : ST_IDLE;
      end
      ST_FLUSH: begin
        if (issue && issue_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_COMMIT: begin
        if (ld_cmt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    out_free = !out_valid_r || out_ready;
    mv_rd    = rd_v_r && out_free;
    in_ready = (state_r == ST_IDLE);
    issue    = (state_r == ST_FLUSH) && (!rd_v_r || mv_rd);
    ld_cmt   = (state_r == ST_COMMIT) && !rd_v_r && out_free;
    flush_go = (state_nxt == ST_FLUSH) && (state_r != ST_FLUSH);
  end

  always_comb begin
    st_wr.en            = store_rec;
    st_wr.addr          = pending_r[IDX_W-1:0];
    st_wr.data.file     = in_word.file_number;
    st_wr.data.chunk    = in_word.chunk_number;
    st_wr.data.segment  = in_word.segment_number;
    st_wr.data.from_loc = in_word.from_location;
    st_wr.data.to_loc   = in_word.to_location;
    st_wr.data.id       = next_id_r;
    st_rd.en            = issue;
    st_rd.addr          = rd_idx_r;
  end

  rwb_store u_store (
    .clk     (clk),
    .wr      (st_wr),
    .rd      (st_rd),
    .rd_data (st_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      pending_r   <= '0;
      flush_n_r   <= '0;
      rd_idx_r    <= '0;
      op_clock_r  <= '0;
      start_r     <= '0;
      next_id_r   <= ID_W'(1);
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (store_rec || (in_acc && in_word.mode == MODE_COMMIT)) begin
        next_id_r <= next_id_r + ID_W'(1);
      end
      if (in_acc && in_word.mode == MODE_ADVANCE) begin
        op_clock_r <= op_clock_r + CLK_W'(in_word.op_increment);
      end
      if (flush_go) begin
        flush_n_r <= store_rec ? pend_inc : pending_r;
        pending_r <= '0;
        start_r   <= '0;
        rd_idx_r  <= '0;
      end else begin
        if (store_rec) begin
          pending_r <= pend_inc;
          if (pending_r == '0) begin
            start_r <= op_clock_r;
          end
        end
        if (issue) begin
          rd_idx_r <= rd_idx_r + IDX_W'(1);
        end
      end
      if (issue) begin
        rd_v_r    <= 1'b1;
        rd_last_r <= issue_last;
      end else if (mv_rd) begin
        rd_v_r <= 1'b0;
      end
      if (mv_rd || ld_cmt) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_word.mode == MODE_COMMIT) begin
      cmt_file_r  <= in_word.file_number;
      cmt_chunk_r <= in_word.chunk_number;
      cmt_id_r    <= next_id_r;
    end
    if (mv_rd) begin
      out_word_r.record_kind        <= KIND_RELOC;
      out_word_r.transaction_number <= st_q.id;
      out_word_r.out_file           <= st_q.file;
      out_word_r.out_chunk          <= st_q.chunk;
      out_word_r.out_segment        <= st_q.segment;
      out_word_r.out_from           <= st_q.from_loc;
      out_word_r.out_to             <= st_q.to_loc;
      out_word_r.last_of_batch      <= rd_last_r;
    end else if (ld_cmt) begin
      out_word_r.record_kind        <= KIND_COMMIT;
      out_word_r.transaction_number <= cmt_id_r;
      out_word_r.out_file           <= cmt_file_r;
      out_word_r.out_chunk          <= cmt_chunk_r;
      out_word_r.out_segment        <= '0;
      out_word_r.out_from           <= '0;
      out_word_r.out_to             <= '0;
      out_word_r.last_of_batch      <= 1'b1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `RWB_ASSERT_NOW(a_pending_bound, 1'b1, pending_r <= CNT_W'(MAX_BATCH), "pending count overflow")
  `RWB_ASSERT_NOW(a_flush_cleared, state_r == ST_FLUSH, pending_r == '0, "batch not cleared in flush")
  `RWB_ASSERT_NEXT(a_flush_ends, issue && issue_last, state_r != ST_FLUSH, "flush overran its count")
  `RWB_ASSERT_NOW(a_commit_last, out_valid_r && out_word_r.record_kind == KIND_COMMIT, out_word_r.last_of_batch, "commit record not marked last")

endmodule

[test/tb_relocation_writeback_batcher.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Relocation writeback batcher testbench
// Drives record, commit, advance and sync words into the batcher under
// several capacity and timeout settings and with random idling on both
// sides. Each accepted word is run through a local model of the batch, and
// every output word is checked field by field against the predicted queue.
// ----------------------------------------------------------------------------
module tb_relocation_writeback_batcher;
  import rwb_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE_TICKS = 20;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_word_t             in_word;
  logic                 out_valid;
  logic                 out_ready;
  out_word_t            out_word;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [PADDR_W-1:0]   paddr;
  logic [PDATA_W-1:0]   pwdata;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  logic [CAP_W-1:0]     capacity_reg;
  logic [TMO_W-1:0]     timeout_reg;
  entry_t               batch_store [MAX_BATCH];
  int unsigned          batch_count;
  logic [CLK_W-1:0]     batch_birth;
  logic [CLK_W-1:0]     op_counter;
  logic [ID_W-1:0]      id_counter;
  out_word_t            expected_records [$];

  int                   mismatches;
  int                   cycles;
  bit                   idle_in_en;
  bit                   idle_out_en;
  int                   hold_req;
  int                   hold_ack;
  int                   hold_left;
  int                   stall_left;

  relocation_writeback_batcher uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned batch_limit();
    if (capacity_reg == 0) return 1;
    if (capacity_reg > MAX_BATCH) return MAX_BATCH;
    return 32'(capacity_reg);
  endfunction

  function automatic void flush_batch();
    out_word_t r;
    for (int i = 0; i < batch_count; i++) begin
      r.record_kind        = KIND_RELOC;
      r.transaction_number = batch_store[i].id;
      r.out_file           = batch_store[i].file;
      r.out_chunk          = batch_store[i].chunk;
      r.out_segment        = batch_store[i].segment;
      r.out_from           = batch_store[i].from_loc;
      r.out_to             = batch_store[i].to_loc;
      r.last_of_batch      = (i + 1 == batch_count);
      expected_records.push_back(r);
    end
    batch_count = 0;
    batch_birth = '0;
  endfunction

  function automatic void predict_writeback(in_word_t w);
    out_word_t r;
    case (w.mode)
      MODE_RECORD: begin
        if (batch_count >= MAX_BATCH) begin
          flush_batch();
        end else begin
          if (batch_count == 0) batch_birth = op_counter;
          batch_store[batch_count].file     = w.file_number;
          batch_store[batch_count].chunk    = w.chunk_number;
          batch_store[batch_count].segment  = w.segment_number;
          batch_store[batch_count].from_loc = w.from_location;
          batch_store[batch_count].to_loc   = w.to_location;
          batch_store[batch_count].id       = id_counter;
          id_counter++;
          batch_count++;
          if (batch_count >= batch_limit()) flush_batch();
        end
      end
      MODE_COMMIT: begin
        r.record_kind        = KIND_COMMIT;
        r.transaction_number = id_counter;
        r.out_file           = w.file_number;
        r.out_chunk          = w.chunk_number;
        r.out_segment        = '0;
        r.out_from           = '0;
        r.out_to             = '0;
        r.last_of_batch      = 1'b1;
        id_counter++;
        expected_records.push_back(r);
      end
      MODE_ADVANCE: begin
        op_counter = op_counter + {32'd0, w.op_increment};
        if (batch_count > 0 && (op_counter - batch_birth) >= {32'd0, timeout_reg})
          flush_batch();
      end
      default: flush_batch();
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // Output side: scoreboard check, long hold-off and random stall bursts.
  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_word);
        mismatches++;
      end else begin
        want = expected_records.pop_front();
        check_field("record_kind", 64'(want.record_kind), 64'(out_word.record_kind));
        check_field("transaction_number", 64'(want.transaction_number),
                    64'(out_word.transaction_number));
        check_field("out_file", 64'(want.out_file), 64'(out_word.out_file));
        check_field("out_chunk", 64'(want.out_chunk), 64'(out_word.out_chunk));
        check_field("out_segment", 64'(want.out_segment), 64'(out_word.out_segment));
        check_field("out_from", want.out_from, out_word.out_from);
        check_field("out_to", want.out_to, out_word.out_to);
        check_field("last_of_batch", 64'(want.last_of_batch),
                    64'(out_word.last_of_batch));
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req != hold_ack) begin
      hold_ack  = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (idle_out_en && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Leaves in_valid high on return; the next call or quiesce sets it.
  task automatic send_word(input in_word_t w);
    int gap;
    gap = 0;
    if (idle_in_en && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (!in_ready);
    predict_writeback(w);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (expected_records.size() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    logic [31:0] stored;
    stored  = (idx == REG_CAPACITY) ? 32'(value[CAP_W-1:0]) : value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_CAPACITY) capacity_reg = value[CAP_W-1:0];
    else timeout_reg = value;
    @(posedge clk);
    check_field("prdata", 64'(stored), 64'(prdata));
    check_field("pready", 64'(1'b1), 64'(pready));
  endtask

  function automatic in_word_t fill_word(logic [1:0] m, logic ones);
    in_word_t w;
    w      = ones ? '1 : '0;
    w.mode = m;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 10) w.mode = MODE_RECORD;
    else if (pick < 13) w.mode = MODE_COMMIT;
    else if (pick < 18) w.mode = MODE_ADVANCE;
    else w.mode = MODE_SYNC;
    w.file_number    = 8'($urandom);
    w.chunk_number   = $urandom;
    w.segment_number = $urandom;
    w.from_location  = {$urandom, $urandom};
    w.to_location    = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       w.op_increment = $urandom_range(0, 64);
      1:       w.op_increment = $urandom;
      2:       w.op_increment = '0;
      default: w.op_increment = $urandom_range(0, 2000);
    endcase
    return w;
  endfunction

  function automatic in_word_t random_word_of(logic [1:0] m);
    in_word_t w;
    w      = random_word();
    w.mode = m;
    return w;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_word(random_word());
  endtask

  task automatic test_field_extremes();
    in_word_t w;
    send_word(fill_word(MODE_RECORD, 1'b1));
    send_word(fill_word(MODE_RECORD, 1'b0));
    send_word(fill_word(MODE_COMMIT, 1'b1));
    send_word(fill_word(MODE_COMMIT, 1'b0));
    w = fill_word(MODE_ADVANCE, 1'b1);
    w.op_increment = '0;
    send_word(w);
    send_word(fill_word(MODE_SYNC, 1'b1));
    quiesce();
  endtask

  task automatic test_empty_flush();
    send_word(fill_word(MODE_SYNC, 1'b0));
    send_word(fill_word(MODE_ADVANCE, 1'b1));
    quiesce();
  endtask

  task automatic test_timeout_edges();
    in_word_t w;
    write_reg(REG_TIMEOUT, 32'd0);
    send_word(random_word_of(MODE_RECORD));
    send_word(fill_word(MODE_ADVANCE, 1'b0));
    quiesce();
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    send_word(random_word_of(MODE_RECORD));
    w = fill_word(MODE_ADVANCE, 1'b0);
    w.op_increment = 32'hFFFF_FFFE;
    send_word(w);
    w.op_increment = 32'd1;
    send_word(w);
    quiesce();
  endtask

  task automatic test_capacity_edges();
    write_reg(REG_CAPACITY, 32'd0);
    send_word(random_word_of(MODE_RECORD));
    quiesce();
    write_reg(REG_CAPACITY, 32'd8);
    repeat (5) send_word(random_word_of(MODE_RECORD));
    quiesce();
    // A lower capacity takes effect on the next record of the open batch.
    write_reg(REG_CAPACITY, 32'd2);
    send_word(random_word_of(MODE_RECORD));
    quiesce();
  endtask

  task automatic test_random_settings();
    logic [31:0] caps [5];
    logic [31:0] tmos [5];
    caps = '{32'd1, 32'd4, 32'd31, 32'd16, 32'd7};
    tmos = '{32'd1, 32'd40, 32'd5000, 32'hFFFF_FFFF, 32'd0};
    for (int k = 0; k < 5; k++) begin
      write_reg(REG_CAPACITY, caps[k]);
      write_reg(REG_TIMEOUT, tmos[k]);
      run_random(28);
      quiesce();
    end
  endtask

  task automatic test_backpressure();
    write_reg(REG_CAPACITY, 32'd16);
    write_reg(REG_TIMEOUT, 32'hFFFF_FFFF);
    hold_req <= hold_req + 1;
    repeat (24) send_word(random_word_of(MODE_RECORD));
    send_word(random_word_of(MODE_SYNC));
    quiesce();
  endtask

  task automatic test_no_idling();
    idle_in_en = 1'b0;
    idle_out_en <= 1'b0;
    write_reg(REG_CAPACITY, 32'd5);
    write_reg(REG_TIMEOUT, 32'd100);
    run_random(40);
    quiesce();
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_word      = '0;
    out_ready    = 1'b0;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    capacity_reg = 5'd16;
    timeout_reg  = 32'd1024;
    batch_count  = 0;
    batch_birth  = '0;
    op_counter   = '0;
    id_counter   = 32'd1;
    mismatches   = 0;
    cycles       = 0;
    idle_in_en   = 1'b1;
    idle_out_en  = 1'b1;
    hold_req     = 0;
    hold_ack     = 0;
    hold_left    = 0;
    stall_left   = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_empty_flush();
    test_timeout_edges();
    test_capacity_edges();
    test_random_settings();
    test_backpressure();
    test_no_idling();

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
